### design/binary_mask_centroid_core_macros.svh
// assertion macros used by the centroid core datapath
`ifndef BINARY_MASK_CENTROID_CORE_MACROS_SVH
`define BINARY_MASK_CENTROID_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define BMC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BMC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/bmc_pkg.sv
// shared types and constants of the binary mask centroid core
package bmc_pkg;

   localparam int CFG_SIZE_W = 12;
   localparam int CFG_MATCH_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 12;
   localparam int PIXEL_W = 8;
   localparam int REQ_DATA_W = 8;
   localparam int OUT_W = 11;
   localparam int RSP_DATA_W = 24;

   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET = 12'd640;
   localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [CFG_MATCH_W-1:0] MATCH_RESET = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_MATCH_VALUE  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_LOAD_X,
      ST_DIV_X,
      ST_LOAD_Y,
      ST_DIV_Y,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic sel_y;
      logic step;
      logic store_x;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
      logic rsp_free;
   } status_type;

endpackage

### design/bmc_ctrl.sv
// sequencer: pixel intake, two divisions per frame, result publish
module bmc_ctrl
   import bmc_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int COL_CNT_W = $clog2(MAX_WIDTH);
   localparam int ROW_CNT_W = $clog2(MAX_HEIGHT);
   localparam int DIV_W = (COL_CNT_W > ROW_CNT_W) ? COL_CNT_W : ROW_CNT_W;
   localparam int CNT_W = $clog2(DIV_W + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      case (state_ff)
         ST_ACCUM: begin
            cmd.accept = 1'b1;
            if (status.frame_end) begin
               state_in = ST_LOAD_X;
            end
         end
         ST_LOAD_X: begin
            cmd.load = 1'b1;
            cnt_in = CNT_W'(DIV_W - 1);
            state_in = ST_DIV_X;
         end
         ST_DIV_X: begin
            cmd.step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_LOAD_Y;
            end
         end
         ST_LOAD_Y: begin
            cmd.store_x = 1'b1;
            cmd.load = 1'b1;
            cmd.sel_y = 1'b1;
            cnt_in = CNT_W'(DIV_W - 1);
            state_in = ST_DIV_Y;
         end
         ST_DIV_Y: begin
            cmd.step = 1'b1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            // hold until the output register can take the result
            if (status.rsp_free) begin
               cmd.publish = 1'b1;
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

endmodule

### design/bmc_dpath.sv
// datapath: config registers, raster counters, sums, shared divider, output register
`include "binary_mask_centroid_core_macros.svh"

module bmc_dpath
   import bmc_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   input  logic [PIXEL_W-1:0]     pixel,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [OUT_W-1:0]       center_x,
   output logic [OUT_W-1:0]       center_y,
   output logic                   found,
   input  cmd_type                cmd,
   output status_type             status
);

   localparam int COL_CNT_W = $clog2(MAX_WIDTH);
   localparam int ROW_CNT_W = $clog2(MAX_HEIGHT);
   localparam int COL_LIM_W = COL_CNT_W + 1;
   localparam int ROW_LIM_W = ROW_CNT_W + 1;
   localparam int DIV_W = (COL_CNT_W > ROW_CNT_W) ? COL_CNT_W : ROW_CNT_W;
   localparam int HIT_W = COL_CNT_W + ROW_CNT_W + 1;
   localparam int SUM_W = HIT_W + DIV_W;

   logic [CFG_SIZE_W-1:0] width_ff, height_ff;
   logic [CFG_MATCH_W-1:0] match_ff;

   logic [COL_CNT_W-1:0] col_ff, col_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   logic [SUM_W-1:0] csum_ff, csum_in, rsum_ff, rsum_in;
   logic [HIT_W-1:0] hit_ff, hit_in;

   logic [SUM_W-1:0] rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DIV_W-1:0] q_ff, q_in, qx_ff;

   logic rsp_valid_ff;
   logic [OUT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic rsp_found_ff;

   logic [COL_LIM_W-1:0] w_eff, col_inc;
   logic [ROW_LIM_W-1:0] h_eff, row_inc;
   logic beat, hit, col_wrap, frame_end, any_hit, take;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         match_ff <= MATCH_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff <= csr_wdata;
            CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            CSR_MATCH_VALUE:  match_ff <= csr_wdata[CFG_MATCH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // size registers: zero means one, saturate at the maximum
   always_comb begin
      if (width_ff == '0) begin
         w_eff = COL_LIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = COL_LIM_W'(MAX_WIDTH);
      end else begin
         w_eff = COL_LIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = ROW_LIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = ROW_LIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_LIM_W'(height_ff);
      end
   end

   assign beat = req_tvalid && cmd.accept;
   assign hit = (pixel == match_ff);
   assign col_inc = COL_LIM_W'(col_ff) + COL_LIM_W'(1);
   assign col_wrap = (col_inc >= w_eff);
   assign row_inc = ROW_LIM_W'(row_ff) + ROW_LIM_W'(col_wrap);
   assign frame_end = beat && (row_inc >= h_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      csum_in = csum_ff;
      rsum_in = rsum_ff;
      hit_in = hit_ff;
      if (beat) begin
         if (hit) begin
            csum_in = csum_ff + SUM_W'(col_ff);
            rsum_in = rsum_ff + SUM_W'(row_ff);
            hit_in = hit_ff + HIT_W'(1);
         end
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else begin
            col_in = col_wrap ? '0 : col_inc[COL_CNT_W-1:0];
            row_in = row_inc[ROW_CNT_W-1:0];
         end
      end
      // sums stay until both means are taken
      if (cmd.publish) begin
         csum_in = '0;
         rsum_in = '0;
         hit_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         csum_ff <= '0;
         rsum_ff <= '0;
         hit_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         csum_ff <= csum_in;
         rsum_ff <= rsum_in;
         hit_ff <= hit_in;
      end
   end

   // restoring divider, one quotient bit per step, msb first
   always_comb begin
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      q_in = q_ff;
      if (cmd.load) begin
         rem_in = cmd.sel_y ? rsum_ff : csum_ff;
         dsr_in = SUM_W'(hit_ff) << (DIV_W - 1);
         q_in = '0;
      end else if (cmd.step) begin
         dsr_in = dsr_ff >> 1;
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            q_in = (q_ff << 1) | DIV_W'(1);
         end else begin
            q_in = q_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff <= q_in;
      if (cmd.store_x) begin
         qx_ff <= q_ff;
      end
   end

   assign any_hit = (hit_ff != '0);
   assign take = rsp_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_x_ff <= any_hit ? OUT_W'(qx_ff) : '0;
         rsp_y_ff <= any_hit ? OUT_W'(q_ff) : '0;
         rsp_found_ff <= any_hit;
      end
   end

   assign status.frame_end = frame_end;
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign center_x = rsp_x_ff;
   assign center_y = rsp_y_ff;
   assign found = rsp_found_ff;

   `BMC_ASSERT_NEXT(a_publish_clears, cmd.publish, (hit_ff == '0) && (csum_ff == '0) && (rsum_ff == '0), "sums not cleared after publish")
   `BMC_ASSERT_NEXT(a_counters_hold, !cmd.accept, $stable(col_ff) && $stable(row_ff), "raster counters moved while intake closed")
   `BMC_ASSERT_NEXT(a_publish_valid, cmd.publish, rsp_valid_ff, "published result not presented")

endmodule

### design/binary_mask_centroid_core.sv
// Binary mask centroid core. Mask pixels arrive one byte per req beat in raster order;
// column and row are counted internally from the frame_width and frame_height registers
// (zero reads as one, values above MAX_WIDTH / MAX_HEIGHT saturate). Each pixel equal to
// match_value adds its column and row to running sums. During a frame one pixel is taken
// every cycle that req_tvalid is high. After the last pixel of a frame the intake closes
// while one shared restoring divider computes the two means one quotient bit per cycle
// (DIV_W = max(clog2(MAX_WIDTH), clog2(MAX_HEIGHT)) bits each) and the result waits for
// the rsp register to be emptied. The result is one rsp beat per frame with center_x and
// center_y in tdata and found in tuser; with no matching pixel both centers are zero and
// found is low. The user writes registers only between frames or while idle; unenforced.
module binary_mask_centroid_core
   import bmc_pkg::*;
#(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [7:0] pixel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [10:0] center_x, [21:11] center_y, zero pad
   output logic                   rsp_tuser    // [0] found
);

   cmd_type cmd;
   status_type status;
   logic [OUT_W-1:0] center_x, center_y;
   logic found;

   bmc_ctrl #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .status(status),
      .cmd(cmd)
   );

   bmc_dpath #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_dpath (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .pixel(req_tdata[PIXEL_W-1:0]),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .center_x(center_x),
      .center_y(center_y),
      .found(found),
      .cmd(cmd),
      .status(status)
   );

   assign req_tready = cmd.accept;
   assign rsp_tdata = {{(RSP_DATA_W - 2 * OUT_W){1'b0}}, center_y, center_x};
   assign rsp_tuser = found;

endmodule

### test/tb_binary_mask_centroid_core.sv
// testbench for the binary mask centroid core: table-driven and random frames against a predictor
`timescale 1ns / 100ps

module tb_binary_mask_centroid_core;
   import bmc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_PIXELS = 1650;
   localparam int CALM_PIXELS = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [OUT_W-1:0] center_x;
      logic [OUT_W-1:0] center_y;
      logic             found;
   } centroid_t;

   typedef enum {ROW_WRITE, ROW_RUN} row_kind_t;

   typedef struct {
      row_kind_t             kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] wdata;
      int                    count;
      logic [PIXEL_W-1:0]    fill;
      int                    hot_at;
      logic [PIXEL_W-1:0]    hot;
      bit                    typed;
      centroid_t             want;
   } row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   // predictor copy of the registers and the frame accumulators
   logic [CFG_SIZE_W-1:0]  width_reg = WIDTH_RESET;
   logic [CFG_SIZE_W-1:0]  height_reg = HEIGHT_RESET;
   logic [CFG_MATCH_W-1:0] match_reg = MATCH_RESET;
   logic [CFG_SIZE_W-1:0]  col_cnt = '0;
   logic [CFG_SIZE_W-1:0]  row_cnt = '0;
   logic [32:0]            col_sum = '0;
   logic [32:0]            row_sum = '0;
   logic [22:0]            hit_count = '0;

   centroid_t centroid_q[$];
   centroid_t typed_want;
   bit        typed_on = 1'b0;
   bit        calm = 1'b0;
   int        gap_pct = 20;
   int        pixels_sent = 0;
   int        error_count = 0;
   int        cycle_count = 0;
   int        stall_left = 0;

   binary_mask_centroid_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [CFG_SIZE_W-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] v,
                                                        input int max_v);
      if (v == '0) return 1;
      if (v > max_v) return max_v[CFG_SIZE_W-1:0];
      return v;
   endfunction

   // one pixel into the accumulators; returns 1 when it closes the frame
   function automatic bit step_centroid(input logic [PIXEL_W-1:0] px, output centroid_t res);
      logic [CFG_SIZE_W-1:0] w;
      logic [CFG_SIZE_W-1:0] h;
      logic [32:0]           quot;
      w = clamp_size(width_reg, DEF_MAX_WIDTH);
      h = clamp_size(height_reg, DEF_MAX_HEIGHT);
      res = '0;
      if (px == match_reg) begin
         col_sum = col_sum + col_cnt;
         row_sum = row_sum + row_cnt;
         hit_count = hit_count + 1'b1;
      end
      col_cnt = col_cnt + 1'b1;
      // a column already past a shrunk width wraps here too
      if (col_cnt >= w) begin
         col_cnt = '0;
         row_cnt = row_cnt + 1'b1;
      end
      if (row_cnt < h) return 1'b0;
      if (hit_count != '0) begin
         quot = col_sum / hit_count;
         res.center_x = quot[OUT_W-1:0];
         quot = row_sum / hit_count;
         res.center_y = quot[OUT_W-1:0];
         res.found = 1'b1;
      end
      col_cnt = '0;
      row_cnt = '0;
      col_sum = '0;
      row_sum = '0;
      hit_count = '0;
      return 1'b1;
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel(input int hit_pct);
      if ($urandom_range(0, 99) < hit_pct) return match_reg;
      return $urandom_range(0, 255);
   endfunction

   function automatic row_t wr_row(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      row_t r;
      r.kind = ROW_WRITE;
      r.index = idx;
      r.wdata = val;
      r.count = 0;
      r.hot_at = -1;
      r.typed = 1'b0;
      return r;
   endfunction

   function automatic row_t run_row(input int n, input logic [PIXEL_W-1:0] fill,
                                    input int hot_at, input logic [PIXEL_W-1:0] hot,
                                    input bit typed, input int want_x, input int want_y,
                                    input bit want_found);
      row_t r;
      r.kind = ROW_RUN;
      r.index = '0;
      r.wdata = '0;
      r.count = n;
      r.fill = fill;
      r.hot_at = hot_at;
      r.hot = hot;
      r.typed = typed;
      r.want.center_x = want_x[OUT_W-1:0];
      r.want.center_y = want_y[OUT_W-1:0];
      r.want.found = want_found;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] px, output bit frame_done);
      centroid_t res;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      frame_done = step_centroid(px, res);
      if (frame_done) centroid_q.push_back(typed_on ? typed_want : res);
      pixels_sent++;
   endtask

   task automatic send_frame(input int hit_pct);
      bit done;
      done = 1'b0;
      while (!done) send_pixel(pick_pixel(hit_pct), done);
   endtask

   // sender holds off until every centroid is out and the divider has settled
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (centroid_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      wait_drained();
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH: width_reg = val;
         CSR_FRAME_HEIGHT: height_reg = val;
         CSR_MATCH_VALUE: match_reg = val[CFG_MATCH_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : rsp_side
      centroid_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (centroid_q.size() == 0) begin
            report_mismatch("result beat with nothing expected", rsp_tdata, 0);
         end else begin
            want = centroid_q.pop_front();
            if (rsp_tdata[OUT_W-1:0] != want.center_x)
               report_mismatch("center_x", rsp_tdata[OUT_W-1:0], want.center_x);
            if (rsp_tdata[2*OUT_W-1:OUT_W] != want.center_y)
               report_mismatch("center_y", rsp_tdata[2*OUT_W-1:OUT_W], want.center_y);
            if (rsp_tuser != want.found)
               report_mismatch("found", rsp_tuser, want.found);
         end
      end
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && !reset && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      row_t rows[$];
      row_t r;
      bit   done;
      int   hit_pct;
      int   random_start;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first row at reset width 640, then rows 1..479 one pixel wide: two hits
      rows.push_back(run_row(640, 8'h00, 639, 8'hFF, 1'b0, 0, 0, 1'b0));
      rows.push_back(wr_row(CSR_FRAME_WIDTH, 12'd1));
      rows.push_back(run_row(479, 8'h00, 478, 8'hFF, 1'b1, 319, 239, 1'b1));
      // zero height reads as one
      rows.push_back(wr_row(CSR_FRAME_HEIGHT, 12'd0));
      rows.push_back(run_row(1, 8'hFF, -1, 8'h00, 1'b1, 0, 0, 1'b1));
      // frame with no match
      rows.push_back(run_row(1, 8'h00, -1, 8'h00, 1'b1, 0, 0, 1'b0));
      // upper write bits of match are dropped, oversize width saturates
      rows.push_back(wr_row(CSR_MATCH_VALUE, 12'hFAA));
      rows.push_back(wr_row(CSR_FRAME_WIDTH, 12'hFFF));
      rows.push_back(run_row(2048, 8'h55, 2047, 8'hAA, 1'b1, 2047, 0, 1'b1));
      rows.push_back(wr_row(CSR_FRAME_WIDTH, 12'd0));
      rows.push_back(wr_row(CSR_FRAME_HEIGHT, 12'hFFF));
      rows.push_back(run_row(2048, 8'h55, 2047, 8'hAA, 1'b1, 0, 2047, 1'b1));
      rows.push_back(wr_row(CSR_MATCH_VALUE, 12'h000));
      rows.push_back(wr_row(CSR_FRAME_WIDTH, 12'd3));
      rows.push_back(wr_row(CSR_FRAME_HEIGHT, 12'd3));
      // write to an index past the register list must change nothing
      rows.push_back(wr_row(CSR_UNUSED, 12'hFFF));
      rows.push_back(run_row(9, 8'h00, -1, 8'h00, 1'b1, 1, 1, 1'b1));
      // width shrunk below the current column mid frame
      rows.push_back(wr_row(CSR_MATCH_VALUE, 12'h7FF));
      rows.push_back(wr_row(CSR_FRAME_WIDTH, 12'd8));
      rows.push_back(wr_row(CSR_FRAME_HEIGHT, 12'd4));
      rows.push_back(run_row(5, 8'hFF, -1, 8'h00, 1'b0, 0, 0, 1'b0));
      rows.push_back(wr_row(CSR_FRAME_WIDTH, 12'd3));
      rows.push_back(run_row(10, 8'h3C, 0, 8'hFF, 1'b0, 0, 0, 1'b0));
      // height shrunk below the current row mid frame ends it on the next beat
      rows.push_back(wr_row(CSR_FRAME_WIDTH, 12'd4));
      rows.push_back(wr_row(CSR_FRAME_HEIGHT, 12'd8));
      rows.push_back(run_row(21, 8'h00, 20, 8'hFF, 1'b0, 0, 0, 1'b0));
      rows.push_back(wr_row(CSR_FRAME_HEIGHT, 12'd2));
      rows.push_back(run_row(1, 8'hFF, -1, 8'h00, 1'b1, 0, 5, 1'b1));

      foreach (rows[i]) begin
         r = rows[i];
         if (r.kind == ROW_WRITE) begin
            write_reg(r.index, r.wdata);
         end else begin
            typed_on = r.typed;
            typed_want = r.want;
            for (int k = 0; k < r.count; k++)
               send_pixel((k == r.hot_at) ? r.hot : r.fill, done);
            typed_on = 1'b0;
         end
      end

      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         calm = (pixels_sent - random_start >= RANDOM_PIXELS - CALM_PIXELS);
         gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
         if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1) == 0)
               write_reg(CSR_FRAME_WIDTH, ($urandom_range(0, 15) == 0) ?
                         $urandom_range(9, 64) : $urandom_range(0, 8));
            if ($urandom_range(0, 1) == 0)
               write_reg(CSR_FRAME_HEIGHT, ($urandom_range(0, 15) == 0) ?
                         $urandom_range(7, 20) : $urandom_range(0, 6));
            if ($urandom_range(0, 1) == 0)
               write_reg(CSR_MATCH_VALUE, $urandom_range(0, 4095));
            if ($urandom_range(0, 7) == 0)
               write_reg(CSR_UNUSED, $urandom_range(0, 4095));
         end
         repeat ($urandom_range(1, 4)) begin
            hit_pct = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(5, 80);
            // broken frame: a size changes partway through
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 12)) send_pixel(pick_pixel(hit_pct), done);
               write_reg($urandom_range(0, 1) ? CSR_FRAME_WIDTH : CSR_FRAME_HEIGHT,
                         $urandom_range(0, 8));
            end
            send_frame(hit_pct);
         end
      end

      calm = 1'b1;
      wait_drained();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/bmc_pkg.sv
design/bmc_ctrl.sv
design/bmc_dpath.sv
design/binary_mask_centroid_core.sv
test/tb_binary_mask_centroid_core.sv
